// ===== rtl/bclp_pkg.sv =====
// ----------------------------------------------------------------------------
// bclp_pkg
// Shared types and constants for the button click / long-press detector.
// ----------------------------------------------------------------------------
package bclp_pkg;

  localparam int TICK_W    = 17;
  localparam int CFG_W     = 16;
  localparam int COUNT_W   = 8;
  localparam int CODE_W    = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // event codes
  localparam logic [CODE_W-1:0] EVT_NONE        = 2'd0;
  localparam logic [CODE_W-1:0] EVT_CLICK_BURST = 2'd1;
  localparam logic [CODE_W-1:0] EVT_LONG_START  = 2'd2;
  localparam logic [CODE_W-1:0] EVT_LONG_REL    = 2'd3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MULTI_CLICK = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] MULTI_CLICK_RST = 16'd400;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] multi_click_ms;
  } bclp_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  event_code;
    logic [COUNT_W-1:0] click_count;
  } bclp_evt_t;

endpackage

// ===== rtl/button_click_long_press_detector_unit.sv =====
// ----------------------------------------------------------------------------
// button_click_long_press_detector_unit
// Multi-click and long-press detector on a stream of 1 ms button samples.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick with the sampled button level
// (1 pressed). Every word produces exactly one output word: an event code on
// out_tuser (none, click burst, long-press start, long-press release) and the
// click count of a burst on out_tdata (zero for other events). The block takes
// one word per clock cycle while the output is not stalled. The input register
// captures a word at its accepting edge, and the state update then lands in the
// result register, which drives out_tvalid. With the output stalled one further
// input word is held. Timing registers (debounce, long press, multi-click gap,
// in ticks) are written on the cfg channel, index 0..2; the user must write
// them only while the stream is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module button_click_long_press_detector_unit import bclp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [0] level, [7:1] zero
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,   // [7:0] click_count
  output logic [CODE_W-1:0]    out_tuser,   // [1:0] event_code
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  bclp_cfg_t cfg;
  bclp_evt_t evt;

  logic               in_vld_r;
  logic               in_level_r;
  logic               out_vld_r;
  logic [CODE_W-1:0]  out_code_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic               advance;

  // a held word moves on when the result slot is empty or draining
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  bclp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bclp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .level (in_level_r),
    .cfg   (cfg),
    .evt   (evt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_level_r <= in_tdata[0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code_r <= evt.event_code;
      out_cnt_r  <= evt.click_count;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_code_r;
  assign out_tdata  = out_cnt_r;

  // a click burst always reports at least one click
  a_burst_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EVT_CLICK_BURST) |-> (out_tdata != '0))
    else $error("click burst with zero count");

  // only a click burst carries a count
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != EVT_CLICK_BURST) |-> (out_tdata == '0))
    else $error("count on a non-burst event");

  // with both registers full and the output stalled, no word may enter
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline full");

  // a held word moves into the result register in the next cycle when it can
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("advanced word lost");

endmodule

// ===== rtl/bclp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bclp_cfg_regs
// Timing registers of the detector, written through the cfg channel.
// ----------------------------------------------------------------------------
module bclp_cfg_regs import bclp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output bclp_cfg_t            cfg
);

  bclp_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= DEBOUNCE_RST;
      cfg_r.long_press_ms  <= LONG_PRESS_RST;
      cfg_r.multi_click_ms <= MULTI_CLICK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:    cfg_r.debounce_ms    <= cfg_data;
        REG_LONG_PRESS:  cfg_r.long_press_ms  <= cfg_data;
        REG_MULTI_CLICK: cfg_r.multi_click_ms <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

endmodule

// ===== rtl/bclp_core.sv =====
// ----------------------------------------------------------------------------
// bclp_core
// Per-tick state update and event decision; state advances when step is high.
// ----------------------------------------------------------------------------
module bclp_core import bclp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      level,
  input  bclp_cfg_t cfg,
  output bclp_evt_t evt
);

  logic               prev_level_r, prev_level_nxt;
  logic [TICK_W-1:0]  tsc_r, tsc_nxt;
  logic [TICK_W-1:0]  tsp_r, tsp_nxt;
  logic               pending_r, pending_nxt;
  logic               fired_r, fired_nxt;
  logic               active_r, active_nxt;
  logic [COUNT_W-1:0] tally_r, tally_nxt;

  logic changed, pressed_now, released;

  assign changed     = (level != prev_level_r);
  assign pressed_now = changed & level;

  always_comb begin
    prev_level_nxt = level;
    tsc_nxt = changed ? '0 : ((tsc_r == TICK_MAX) ? tsc_r : tsc_r + 1'b1);
    tsp_nxt = pressed_now ? '0 : ((tsp_r == TICK_MAX) ? tsp_r : tsp_r + 1'b1);
    pending_nxt = pressed_now | pending_r;
    fired_nxt   = pressed_now ? 1'b0 : fired_r;
    active_nxt  = pressed_now ? 1'b0 : active_r;
    tally_nxt   = tally_r;
    evt.event_code  = EVT_NONE;
    evt.click_count = '0;

    released = !level && (tsc_nxt > {1'b0, cfg.debounce_ms});

    if (released && active_nxt) begin
      // debounced end of a long press owns the tick
      active_nxt     = 1'b0;
      pending_nxt    = 1'b0;
      evt.event_code = EVT_LONG_REL;
    end else begin
      if (released) begin
        if (pending_nxt && !fired_nxt && (tally_nxt != COUNT_MAX))
          tally_nxt = tally_nxt + 1'b1;
        pending_nxt = 1'b0;
      end
      if (level && pending_nxt && !fired_nxt &&
          (tsp_nxt >= {1'b0, cfg.long_press_ms})) begin
        fired_nxt      = 1'b1;
        active_nxt     = 1'b1;
        tally_nxt      = '0;
        evt.event_code = EVT_LONG_START;
      end
      if ((tally_nxt != '0) && (tsc_nxt > {1'b0, cfg.multi_click_ms})) begin
        evt.event_code  = EVT_CLICK_BURST;
        evt.click_count = tally_nxt;
        tally_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      tsc_r        <= '0;
      tsp_r        <= '0;
      pending_r    <= 1'b0;
      fired_r      <= 1'b0;
      active_r     <= 1'b0;
      tally_r      <= '0;
    end else if (step) begin
      prev_level_r <= prev_level_nxt;
      tsc_r        <= tsc_nxt;
      tsp_r        <= tsp_nxt;
      pending_r    <= pending_nxt;
      fired_r      <= fired_nxt;
      active_r     <= active_nxt;
      tally_r      <= tally_nxt;
    end
  end

endmodule
